@@ design/cdn_pkg.sv @@
// ----------------------------------------------------------------------------
// cdn_pkg
// Shared types and constants for the counter delta to nanoseconds converter.
// ----------------------------------------------------------------------------
package cdn_pkg;

  localparam int CountW = 64;
  localparam int FreqW  = 32;
  localparam int CmdW   = 2;
  localparam int NsW    = 30;
  localparam int ProdW  = FreqW + NsW;

  localparam logic [NsW-1:0]   NsPerSecond = 30'd1000000000;
  localparam logic [FreqW-1:0] FreqReset   = 32'd10000000;

  localparam logic [CmdW-1:0] CMD_RESTART = 2'd0;
  localparam logic [CmdW-1:0] CMD_TICK    = 2'd1;
  localparam logic [CmdW-1:0] CMD_ELAPSED = 2'd2;

  typedef struct packed {
    logic              start;
    logic [CountW-1:0] dividend;
    logic [FreqW-1:0]  divisor;
  } cdn_div_req_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] quotient;
    logic [FreqW-1:0]  remainder;
  } cdn_div_rsp_t;

endpackage

@@ design/cdn_div.sv @@
// ----------------------------------------------------------------------------
// cdn_div
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. Results hold after done until the next start.
// ----------------------------------------------------------------------------
module cdn_div
  import cdn_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cdn_div_req_t req,
  output cdn_div_rsp_t rsp
);

  localparam int CntW = $clog2(CountW);

  logic [CountW-1:0] quo_r, quo_nxt;
  logic [FreqW-1:0]  rem_r, rem_nxt;
  logic [FreqW-1:0]  dvs_r;
  logic [CntW-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [FreqW:0]    shifted;
  logic [FreqW:0]    diff;
  logic              fits;

  // shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    shifted = {rem_r, quo_r[CountW-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[FreqW-1:0] : shifted[FreqW-1:0];
    quo_nxt = {quo_r[CountW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '1;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

@@ design/cdn_mul.sv @@
// ----------------------------------------------------------------------------
// cdn_mul
// Registered 32 x 30 bit multiplier by the number of nanoseconds per second.
// ----------------------------------------------------------------------------
module cdn_mul
  import cdn_pkg::*;
(
  input  logic             clk,
  input  logic [FreqW-1:0] mul_a,
  output logic [ProdW-1:0] prod
);

  logic [ProdW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {{NsW{1'b0}}, mul_a} * {{FreqW{1'b0}}, NsPerSecond};
  end

  assign prod = prod_r;

endmodule

@@ design/counter_delta_to_nanoseconds_top.sv @@
// ----------------------------------------------------------------------------
// counter_delta_to_nanoseconds_top
// Converts tick counter intervals to nanoseconds with a shared divider.
// ----------------------------------------------------------------------------
// Input channel in_*: tuser carries the command (restart, tick, elapsed),
// tdata the sampled 64-bit counter. Result channel out_*: one 64-bit word of
// nanoseconds per input word. The user writes the tick frequency through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block itself does
// not enforce this.
// A tick or elapsed word runs through two passes of the radix-2 divider
// (interval by frequency, then remainder times 1e9 by frequency) with handoff,
// remainder multiply and final add. The whole-seconds multiply on the
// registered 32 x 30 multiplier runs in the shadow of the second division. A
// restart, an unused command or a zero frequency goes from accept straight to
// the done state, which gives its result.
// in_tready is high only while the sequencer is idle, so one word is in work
// at a time: the next word is taken once the last result has moved into the
// output register. The result sits there; a new word may be taken while it
// waits, and a stalled receiver holds the finished next result in the
// sequencer until the output register frees up.
// Synchronous reset clears both counts to zero, sets the frequency to
// 10000000 and drops out_tvalid.
// ----------------------------------------------------------------------------
module counter_delta_to_nanoseconds_top
  import cdn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CountW-1:0] in_tdata,   // counter_now
  input  logic [CmdW-1:0]   in_tuser,   // command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CountW-1:0] out_tdata,  // nanoseconds
  input  logic              cfg_wr_en,
  input  logic [FreqW-1:0]  cfg_wr_data // tick_frequency
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV1     = 3'd1;
  localparam logic [2:0] ST_MUL_REST = 3'd2;
  localparam logic [2:0] ST_MUL_LO   = 3'd3;
  localparam logic [2:0] ST_MUL_HI   = 3'd4;
  localparam logic [2:0] ST_ACC_HI   = 3'd5;
  localparam logic [2:0] ST_DIV2     = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [FreqW-1:0]  freq_r;
  logic [CountW-1:0] start_r, start_nxt;
  logic [CountW-1:0] last_r, last_nxt;
  logic [CountW-1:0] whole_r, whole_nxt;
  logic [CountW-1:0] acc_r, acc_nxt;
  logic              out_valid_r;
  logic [CountW-1:0] out_data_r;
  logic              accept;
  logic              out_free;
  logic [CountW-1:0] delta;
  cdn_div_req_t      div_req;
  cdn_div_rsp_t      div_rsp;
  logic [FreqW-1:0]  mul_a;
  logic [ProdW-1:0]  prod;

  cdn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cdn_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .prod  (prod)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign delta     = in_tdata - ((in_tuser == CMD_TICK) ? last_r : start_r);

  always_comb begin
    state_nxt        = state_r;
    start_nxt        = start_r;
    last_nxt         = last_r;
    whole_nxt        = whole_r;
    acc_nxt          = acc_r;
    div_req.start    = 1'b0;
    div_req.dividend = delta;
    div_req.divisor  = freq_r;
    mul_a            = div_rsp.remainder;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt   = '0;
          state_nxt = ST_DONE;
          if (in_tuser == CMD_RESTART) begin
            start_nxt = in_tdata;
            last_nxt  = in_tdata;
          end else if (in_tuser == CMD_TICK || in_tuser == CMD_ELAPSED) begin
            if (in_tuser == CMD_TICK) begin
              last_nxt = in_tdata;
            end
            if (freq_r != '0) begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV1;
            end
          end
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          whole_nxt = div_rsp.quotient;
          state_nxt = ST_MUL_REST;
        end
      end
      ST_MUL_REST: begin
        mul_a     = div_rsp.remainder;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        // prod now holds remainder * 1e9, below 2^62
        div_req.start    = 1'b1;
        div_req.dividend = {{(CountW-ProdW){1'b0}}, prod};
        mul_a            = whole_r[FreqW-1:0];
        state_nxt        = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        acc_nxt   = {{(CountW-ProdW){1'b0}}, prod};
        mul_a     = whole_r[CountW-1:FreqW];
        state_nxt = ST_ACC_HI;
      end
      ST_ACC_HI: begin
        // upper half of whole times 1e9 only counts in its low 32 bits
        acc_nxt   = acc_r + {prod[FreqW-1:0], {FreqW{1'b0}}};
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          acc_nxt   = acc_r + div_rsp.quotient;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      freq_r      <= FreqReset;
      start_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      last_r  <= last_nxt;
      if (cfg_wr_en) begin
        freq_r <= cfg_wr_data;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    whole_r <= whole_nxt;
    acc_r   <= acc_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/cdn_checker.sv @@
// ----------------------------------------------------------------------------
// cdn_checker
// Port-level checks for the counter delta to nanoseconds converter.
// ----------------------------------------------------------------------------
module cdn_checker
  import cdn_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [CmdW-1:0]   in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [CountW-1:0] out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set right after reset");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // a restart taken while the output is free answers zero
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_RESTART && !out_tvalid
    |=> ##1 out_tvalid && out_tdata == '0)
    else $error("restart did not answer zero");

endmodule

bind counter_delta_to_nanoseconds_top cdn_checker u_cdn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
